>>> hw/rtl/dfa_stream_acceptor_assert.svh
// Assertion macros shared by the acceptor RTL.
`ifndef DFA_STREAM_ACCEPTOR_ASSERT_SVH
`define DFA_STREAM_ACCEPTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define DFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define DFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define DFA_ASSERT(lbl, prop, msg)
`define DFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/dfa_pkg.sv
// Types and constants of the programmable automaton.
package dfa_pkg;

    localparam int STATE_W  = 4;
    localparam int SYMBOL_W = 8;
    localparam int OUT_LEN_W = 16;

    typedef enum logic [1:0] {
        CMD_WR_TRANS = 2'd0,
        CMD_WR_FINAL = 2'd1,
        CMD_BEGIN    = 2'd2,
        CMD_FEED     = 2'd3
    } t_dfa_cmd;

    typedef struct packed {
        t_dfa_cmd              cmd;
        logic [STATE_W-1:0]    state_index;
        logic [SYMBOL_W-1:0]   symbol;
        logic [STATE_W-1:0]    next_state;
        logic                  final_flag;
    } t_dfa_in;

    typedef struct packed {
        logic                  accepted;
        logic                  dead;
        logic [OUT_LEN_W-1:0]  longest_length;
        logic [OUT_LEN_W-1:0]  consumed_length;
        logic                  duplicate_error;
    } t_dfa_out;

    // One transition table entry.
    typedef struct packed {
        logic                  valid;
        logic [STATE_W-1:0]    next_state;
    } t_dfa_entry;

    localparam int ENTRY_W = $bits(t_dfa_entry);

endpackage

>>> hw/rtl/dfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/dfa_clear.sv
// Post-reset sweep that clears the transition table one entry a cycle.
module dfa_clear #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_busy,
    output logic [AW-1:0] o_addr
);

    logic          r_busy;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            // stop after the last entry
            if (r_addr == {AW{1'b1}}) begin
                r_busy <= 1'b0;
            end
            r_addr <= r_addr + AW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule

>>> hw/rtl/dfa_stream_acceptor.sv
// Top level of the programmable deterministic automaton over a symbol stream.
`include "dfa_stream_acceptor_assert.svh"

// The block takes one beat per cycle unless its input stalls: a transition
// write, a final-mark write, a begin or a symbol, and returns one result beat
// for each, in order. A beat is looked up in the transition RAM at the edge it
// is accepted, then resolved in execute from the RAM output and loaded into the
// output register once that is free or draining; a new beat can enter while the
// last one is still in execute. The RAM output feeds the next read address
// directly, which is what sets the one-beat-per-cycle figure for consecutive
// symbols. A transition write that lands on the same entry the next beat reads
// is forwarded from a one-entry bypass register. The output register decouples
// the two sides: the input stalls only when a beat waits in execute behind a
// held result that the output is stalling, or during the clearing pass. After
// reset the transition table is swept clean at one entry per cycle, all
// 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) entries (4096 with the defaults);
// no input beat is taken meanwhile, but the start-state register can be written
// at any time. Final marks live in flip-flops and are cleared by reset directly.
// Lengths saturate at 2**LENGTH_BITS-1 and the low 16 bits are reported.
module dfa_stream_acceptor
    import dfa_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 256,
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [STATE_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_dfa_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_dfa_out           o_out_data
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int YW    = $clog2(NUM_SYMBOLS);
    localparam int AW    = SW + YW;
    localparam int DEPTH = 1 << AW;

    // architectural run state
    logic [STATE_W-1:0]     r_start;
    logic [STATE_W-1:0]     r_cur,      n_cur;
    logic                   r_dead,     n_dead;
    logic [LENGTH_BITS-1:0] r_consumed, n_consumed;
    logic [LENGTH_BITS-1:0] r_longest,  n_longest;
    logic [NUM_STATES-1:0]  r_final,    n_final;

    // execute stage
    logic                   r_s1_valid;
    t_dfa_in                r_s1_item;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_fwd_hit;
    t_dfa_entry             r_fwd_ent;

    // output register
    logic                   r_out_valid;
    t_dfa_out               r_out_data;

    logic                   clr_busy;
    logic [AW-1:0]          clr_addr;
    logic                   in_accept;
    logic                   s1_adv;
    logic                   s1_commit;
    logic                   s1_wr_en;
    logic                   s1_dup;
    logic [LENGTH_BITS-1:0] consumed_inc;
    logic [STATE_W-1:0]     addr_state;
    logic [AW-1:0]          rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [ENTRY_W-1:0]     ram_wr_data;
    t_dfa_entry             s1_ent;
    t_dfa_entry             s1_wr_ent;
    t_dfa_out               s1_res;

    function automatic logic state_final(input logic [NUM_STATES-1:0] marks,
                                         input logic [STATE_W-1:0]    s);
        logic hit;
        hit = 1'b0;
        if (32'(s) < NUM_STATES) begin
            hit = marks[SW'(s)];
        end
        return hit;
    endfunction

    dfa_clear #(
        .AW (AW)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_addr  (clr_addr)
    );

    dfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Handshake: the execute stage moves on whenever the output register is free
    // or being drained this cycle.
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_commit  = r_s1_valid && s1_adv;
    assign o_in_stall = clr_busy || (r_s1_valid && !s1_adv);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Take the bypassed entry when the previous beat just wrote this address.
    assign s1_ent = r_fwd_hit ? r_fwd_ent : t_dfa_entry'(ram_rd_data);

    assign consumed_inc = (r_consumed == {LENGTH_BITS{1'b1}}) ? r_consumed
                                                               : r_consumed + LENGTH_BITS'(1);

    // Resolve the beat in the execute stage.
    always_comb begin
        n_cur      = r_cur;
        n_dead     = r_dead;
        n_consumed = r_consumed;
        n_longest  = r_longest;
        n_final    = r_final;
        s1_dup     = 1'b0;
        s1_wr_en   = 1'b0;
        s1_wr_ent.valid      = 1'b1;
        s1_wr_ent.next_state = r_s1_item.next_state;
        unique case (r_s1_item.cmd)
            CMD_WR_TRANS: begin
                if (32'(r_s1_item.state_index) < NUM_STATES &&
                    32'(r_s1_item.symbol) < NUM_SYMBOLS &&
                    32'(r_s1_item.next_state) < NUM_STATES) begin
                    // keep the old entry and flag the clash
                    if (s1_ent.valid) begin
                        s1_dup = 1'b1;
                    end else begin
                        s1_wr_en = s1_commit;
                    end
                end
            end
            CMD_WR_FINAL: begin
                if (32'(r_s1_item.state_index) < NUM_STATES) begin
                    n_final[SW'(r_s1_item.state_index)] = r_s1_item.final_flag;
                end
            end
            CMD_BEGIN: begin
                n_cur      = r_start;
                n_dead     = 1'b0;
                n_consumed = '0;
                n_longest  = '0;
            end
            CMD_FEED: begin
                // a dead run drops the symbol
                if (!r_dead) begin
                    if (32'(r_cur) < NUM_STATES &&
                        32'(r_s1_item.symbol) < NUM_SYMBOLS && s1_ent.valid) begin
                        n_cur      = s1_ent.next_state;
                        n_consumed = consumed_inc;
                        if (state_final(r_final, s1_ent.next_state)) begin
                            n_longest = consumed_inc;
                        end
                    end else begin
                        n_dead = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        s1_res.accepted        = !n_dead && state_final(n_final, n_cur);
        s1_res.dead            = n_dead;
        s1_res.longest_length  = OUT_LEN_W'(n_longest);
        s1_res.consumed_length = OUT_LEN_W'(n_consumed);
        s1_res.duplicate_error = s1_dup;
    end

    // Read address for the incoming beat; a symbol follows the state the beat
    // in execute is about to leave behind.
    always_comb begin
        addr_state = r_s1_valid ? n_cur : r_cur;
        if (i_in_data.cmd == CMD_FEED) begin
            rd_addr = {SW'(addr_state), YW'(i_in_data.symbol)};
        end else begin
            rd_addr = {SW'(i_in_data.state_index), YW'(i_in_data.symbol)};
        end
    end

    // The clearing pass owns the write port until it finishes.
    always_comb begin
        if (clr_busy) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = s1_wr_en;
            ram_wr_addr = r_s1_addr;
            ram_wr_data = ENTRY_W'(s1_wr_ent);
        end
    end

    // Control and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_cur       <= '0;
            r_dead      <= 1'b0;
            r_consumed  <= '0;
            r_longest   <= '0;
            r_final     <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            if (s1_commit) begin
                r_cur      <= n_cur;
                r_dead     <= n_dead;
                r_consumed <= n_consumed;
                r_longest  <= n_longest;
                r_final    <= n_final;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_wr_en && (r_s1_addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the beat in execute and the bypass entry until replaced.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
            r_s1_addr <= rd_addr;
            r_fwd_ent <= s1_wr_ent;
        end
        if (s1_commit) begin
            r_out_data <= s1_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `DFA_ASSERT(a_no_beat_while_clearing, clr_busy |-> !r_s1_valid, "beat in execute during clearing pass")
    `DFA_ASSERT(a_clear_done_sticky, !clr_busy |=> !clr_busy, "clearing pass restarted")
    `DFA_ASSERT(a_commit_gives_result, s1_commit |=> o_out_valid, "resolved beat produced no result")
    `DFA_ASSERT(a_dead_feed_holds, (s1_commit && r_s1_item.cmd == CMD_FEED && r_dead) |=> ($stable(r_cur) && r_dead && $stable(r_consumed)), "dead run moved on a symbol")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the programmable automaton stream acceptor.
`timescale 1ns / 1ps

module testbench;
    import dfa_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_BEATS   = 235;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    // One directed row: the beat, and, where it is obvious, the result it must give.
    typedef struct packed {
        t_dfa_in  beat;
        logic     typed;
        t_dfa_out fixed;
    } t_dir_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [STATE_W-1:0] i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    t_dfa_in            i_in_data     = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    t_dfa_out           o_out_data;

    dfa_stream_acceptor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    // ------------------------------------------------------------------
    // Automaton mirror: table, final marks and the state of the run.
    // ------------------------------------------------------------------
    logic               trans_present [0:4095];
    logic [STATE_W-1:0] trans_dest    [0:4095];
    logic               accepting     [0:15];
    logic [STATE_W-1:0] run_state     = '0;
    logic               run_dead      = 1'b0;
    logic [15:0]        run_consumed  = '0;
    logic [15:0]        run_longest   = '0;
    logic [STATE_W-1:0] start_cfg     = '0;

    t_dfa_out status_q [$];   // results still owed by the block, oldest first

    int  errors          = 0;
    int  cycle_count     = 0;
    int  beats_in        = 0;
    int  results_checked = 0;
    int  accept_seen     = 0;
    int  dead_seen       = 0;
    int  dup_seen        = 0;
    int  longest_seen    = 0;
    int  burst_left      = 0;
    bit  gaps_on         = 1'b1;
    bit  hold_req        = 1'b0;

    initial begin
        foreach (trans_present[a]) begin
            trans_present[a] = 1'b0;
            trans_dest[a]    = '0;
        end
        foreach (accepting[s]) accepting[s] = 1'b0;
    end

    // Directed rows. A typed result is given after reset and on duplicate errors;
    // every other row is left to the mirror.
    // Result fields: accepted, dead, longest, consumed, duplicate.
    t_dir_row dir_rows [23] = '{
        // fresh table: first write lands, the second on the same entry is refused
        '{'{CMD_WR_TRANS, 4'd0,  8'h00, 4'd1,  1'b0}, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 1'b0}},
        '{'{CMD_WR_TRANS, 4'd0,  8'h00, 4'd15, 1'b1}, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 1'b1}},
        '{'{CMD_WR_FINAL, 4'd1,  8'hFF, 4'd15, 1'b1}, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0, 1'b0}},
        // feed with no begin: run carries on from state 0
        '{'{CMD_FEED,     4'd15, 8'h00, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_WR_TRANS, 4'd1,  8'hFF, 4'd15, 1'b0}, 1'b0, '0},
        '{'{CMD_WR_TRANS, 4'd15, 8'hFF, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_WR_FINAL, 4'd15, 8'h00, 4'd0,  1'b1}, 1'b0, '0},
        '{'{CMD_FEED,     4'd0,  8'hFF, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     4'd0,  8'hFF, 4'd0,  1'b0}, 1'b0, '0},
        // mark and unmark the current state mid-sequence
        '{'{CMD_WR_FINAL, 4'd0,  8'h00, 4'd0,  1'b1}, 1'b0, '0},
        '{'{CMD_WR_FINAL, 4'd0,  8'h00, 4'd0,  1'b0}, 1'b0, '0},
        // missing transition kills the run, later symbols are ignored
        '{'{CMD_FEED,     4'd0,  8'hAA, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     4'd0,  8'h00, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_WR_TRANS, 4'd0,  8'h55, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_BEGIN,    4'd0,  8'h00, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     4'd0,  8'h00, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_WR_FINAL, 4'd1,  8'h00, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     4'd0,  8'hFF, 4'd0,  1'b0}, 1'b0, '0},
        // duplicate in the middle of a live, accepting run
        '{'{CMD_WR_TRANS, 4'd15, 8'hFF, 4'd5,  1'b0}, 1'b1, '{1'b1, 1'b0, 16'd2, 16'd2, 1'b1}},
        '{'{CMD_FEED,     4'd0,  8'h55, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_BEGIN,    4'd15, 8'hFF, 4'd15, 1'b1}, 1'b0, '0},
        '{'{CMD_FEED,     4'd0,  8'h55, 4'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_WR_TRANS, 4'd7,  8'h80, 4'd8,  1'b1}, 1'b0, '0}
    };

    // Apply one beat to the mirror and return the status it should report.
    function automatic t_dfa_out advance_automaton(input t_dfa_in b);
        t_dfa_out   res;
        logic [11:0] addr;
        res = '0;
        case (b.cmd)
            CMD_WR_TRANS: begin
                addr = {b.state_index, b.symbol};
                if (trans_present[addr]) begin
                    res.duplicate_error = 1'b1;   // keep the old entry
                end else begin
                    trans_present[addr] = 1'b1;
                    trans_dest[addr]    = b.next_state;
                end
            end
            CMD_WR_FINAL: accepting[b.state_index] = b.final_flag;
            CMD_BEGIN: begin
                run_state    = start_cfg;
                run_dead     = 1'b0;
                run_consumed = '0;
                run_longest  = '0;
            end
            default: begin
                addr = {run_state, b.symbol};
                if (!run_dead) begin
                    if (trans_present[addr]) begin
                        run_state = trans_dest[addr];
                        if (run_consumed != LEN_MAX) run_consumed = run_consumed + 16'd1;
                        if (accepting[run_state]) run_longest = run_consumed;
                    end else begin
                        run_dead = 1'b1;
                    end
                end
            end
        endcase
        res.accepted        = !run_dead && accepting[run_state];
        res.dead            = run_dead;
        res.longest_length  = run_longest;
        res.consumed_length = run_consumed;
        return res;
    endfunction

    function automatic t_dfa_in pack_beat(input t_dfa_cmd c, input logic [3:0] s,
                                          input logic [7:0] y, input logic [3:0] n,
                                          input logic f);
        t_dfa_in b;
        b.cmd         = c;
        b.state_index = s;
        b.symbol      = y;
        b.next_state  = n;
        b.final_flag  = f;
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout: %0d results still owed", status_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side. Drive at the falling edge, see acceptance at the rising
    // edge. Valid stays high from one beat to the next; only a gap lowers it.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_dfa_in b, input bit typed, input t_dfa_out fixed);
        t_dfa_out predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // The mirror always advances so that later rows stay in step.
        predicted = advance_automaton(b);
        status_q.push_back(typed ? fixed : predicted);
        beats_in++;
    endtask

    task automatic pause(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Offer a beat in the current burst; if gaps are on, open a gap as it runs out.
    task automatic offer(input t_dfa_in b, input bit typed = 1'b0,
                         input t_dfa_out fixed = '0);
        if (gaps_on && burst_left == 0) begin
            pause($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        send_beat(b, typed, fixed);
    endtask

    // Drop valid and hold until every owed result has come back, plus a margin
    // for the two-stage pipeline.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the start state; only done with the block idle.
    task automatic write_start(input logic [STATE_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        start_cfg = value;
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern of its own, plus a long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // hold off so the block fills and pushes back on its input
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_SPARSE:   i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PERIODIC: i_out_stall <= ((tick % 5) < 2);
                    default:        i_out_stall <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    // Compare every accepted result beat with the oldest owed status.
    always @(posedge i_clk) begin : result_check
        t_dfa_out wanted;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing owed", o_out_data));
            end else begin
                wanted = status_q.pop_front();
                results_checked++;
                if (o_out_data.accepted !== wanted.accepted)
                    report_mismatch($sformatf("accepted %b, want %b",
                                              o_out_data.accepted, wanted.accepted));
                if (o_out_data.dead !== wanted.dead)
                    report_mismatch($sformatf("dead %b, want %b",
                                              o_out_data.dead, wanted.dead));
                if (o_out_data.longest_length !== wanted.longest_length)
                    report_mismatch($sformatf("longest %0d, want %0d",
                                              o_out_data.longest_length,
                                              wanted.longest_length));
                if (o_out_data.consumed_length !== wanted.consumed_length)
                    report_mismatch($sformatf("consumed %0d, want %0d",
                                              o_out_data.consumed_length,
                                              wanted.consumed_length));
                if (o_out_data.duplicate_error !== wanted.duplicate_error)
                    report_mismatch($sformatf("duplicate %b, want %b",
                                              o_out_data.duplicate_error,
                                              wanted.duplicate_error));
                if (o_out_data.accepted === 1'b1) accept_seen++;
                if (o_out_data.dead === 1'b1) dead_seen++;
                if (o_out_data.duplicate_error === 1'b1) dup_seen++;
                if (int'(o_out_data.longest_length) > longest_seen)
                    longest_seen = int'(o_out_data.longest_length);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [STATE_W-1:0] grp   [5];
        logic [7:0]         alpha [3];
        logic [STATE_W-1:0] st;
        logic [7:0]         sym;
        int                 rand_base;
        int                 len;
        int                 pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. The block sweeps its table first and stalls meanwhile.
        foreach (dir_rows[r]) offer(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].fixed);

        // Random phases. Each wires a small group of states over a small
        // alphabet so that sequences run long, then mixes sequences with noise.
        rand_base = beats_in;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       st = 4'd15;
                1:       st = 4'd0;
                default: st = 4'($urandom_range(0, 15));
            endcase
            // pause here until the block has returned everything
            write_start(st);
            gaps_on = (ph % 3 != 2) && (ph != 3);
            if (ph == 3) hold_req = 1'b1;

            grp[0] = st;
            for (int k = 1; k < 5; k++) grp[k] = 4'($urandom_range(0, 15));
            for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));

            for (int k = 0; k < 5; k++) begin
                for (int j = 0; j < 3; j++)
                    offer(pack_beat(CMD_WR_TRANS, grp[k], alpha[j],
                                    grp[$urandom_range(0, 4)], 1'($urandom_range(0, 1))));
                offer(pack_beat(CMD_WR_FINAL, grp[k], 8'($urandom()), 4'($urandom()),
                                ($urandom_range(0, 2) != 0)));
            end

            while (beats_in - rand_base < (ph + 1) * PHASE_BEATS) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    offer(pack_beat(CMD_BEGIN, 4'($urandom()), 8'($urandom()),
                                    4'($urandom()), 1'($urandom())));
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
                    repeat (len) begin
                        // now and then rewire the automaton mid-sequence
                        if ($urandom_range(0, 24) == 0)
                            offer(pack_beat(t_dfa_cmd'($urandom_range(0, 1)), grp[$urandom_range(0, 4)],
                                            alpha[$urandom_range(0, 2)], 4'($urandom()),
                                            1'($urandom())));
                        sym = ($urandom_range(0, 19) == 0) ? 8'($urandom())
                                                           : alpha[$urandom_range(0, 2)];
                        offer(pack_beat(CMD_FEED, 4'($urandom()), sym, 4'($urandom()),
                                        1'($urandom())));
                    end
                end else if (pick < 9) begin
                    offer(t_dfa_in'(19'($urandom())));
                end else begin
                    offer(pack_beat(CMD_WR_FINAL, 4'($urandom()), 8'($urandom()),
                                    4'($urandom()), 1'($urandom())));
                end
            end
        end

        settle();
        $display("summary: %0d beats sent (%0d directed, %0d random), %0d checked",
                 beats_in, rand_base, beats_in - rand_base, results_checked);
        $display("summary: %0d accepting, %0d dead, %0d duplicate writes, longest prefix %0d",
                 accept_seen, dead_seen, dup_seen, longest_seen);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
